// ===== sv/iwm_pkg.sv =====
`default_nettype none

package iwm_pkg;

  // Pixel and register width; the datapath follows from this.
  localparam int unsigned PIXEL_BITS   = 16;
  localparam int unsigned PROD_BITS    = 2 * PIXEL_BITS;
  // Quotient bits retired per divider stage.
  localparam int unsigned DIV_BITS     = 2;
  localparam int unsigned DIV_STAGES   = (PIXEL_BITS + DIV_BITS - 1) / DIV_BITS;
  localparam int unsigned CFG_IDX_BITS = 2;

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [PROD_BITS-1:0]  prod_word_t;

  localparam logic [31:0] LEVEL_TOP = 32'd65535;
  localparam pix_t IN_LOW_RST   = '0;
  localparam pix_t IN_HIGH_RST  = pix_t'(LEVEL_TOP);
  localparam pix_t OUT_LOW_RST  = '0;
  localparam pix_t OUT_HIGH_RST = pix_t'(LEVEL_TOP);

  typedef enum logic [1:0] {
    REGION_BELOW = 2'd0,
    REGION_RAMP  = 2'd1,
    REGION_ABOVE = 2'd2
  } region_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_IN_LOW   = 2'd0,
    CFG_IN_HIGH  = 2'd1,
    CFG_OUT_LOW  = 2'd2,
    CFG_OUT_HIGH = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    pix_t in_low;
    pix_t in_high;
    pix_t out_low;
    pix_t out_high;
  } cfg_t;

  // Per-item tags that ride along with the arithmetic.
  typedef struct packed {
    region_e region;
    logic    neg;
  } side_t;

  typedef struct packed {
    side_t      side;
    prod_word_t prod;
  } prod_t;

  typedef struct packed {
    side_t side;
    pix_t  quo;
    logic  rem_nz;
  } quot_t;

endpackage

`default_nettype wire

// ===== sv/iwm_pix_if.sv =====
`default_nettype none

interface iwm_pix_if import iwm_pkg::*; ();
  logic valid;
  logic ready;
  pix_t pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

`default_nettype wire

// ===== sv/iwm_res_if.sv =====
`default_nettype none

interface iwm_res_if import iwm_pkg::*; ();
  logic       valid;
  logic       ready;
  pix_t       pixel_out;
  logic [1:0] region;

  modport source (output valid, output pixel_out, output region, input ready);
  modport sink   (input valid, input pixel_out, input region, output ready);
endinterface

`default_nettype wire

// ===== sv/iwm_front.sv =====
`default_nettype none

module iwm_front import iwm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire pix_t  pixel_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output prod_t      out_o
);

  logic  a_valid_q;
  side_t a_side_q;
  pix_t  a_off_q;
  pix_t  a_mag_q;
  logic  a_ready;

  logic  b_valid_q;
  prod_t b_q;
  logic  b_ready;

  side_t side_d;
  pix_t  mag_d;

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  // Classify against the window and pick the ramp magnitude.
  always_comb begin
    side_d.neg = cfg_i.out_high < cfg_i.out_low;
    if (pixel_i < cfg_i.in_low) begin
      side_d.region = REGION_BELOW;
    end else if (pixel_i >= cfg_i.in_high) begin
      side_d.region = REGION_ABOVE;
    end else begin
      side_d.region = REGION_RAMP;
    end
    mag_d = side_d.neg ? (cfg_i.out_low - cfg_i.out_high)
                       : (cfg_i.out_high - cfg_i.out_low);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_side_q <= side_d;
      a_off_q  <= pixel_i - cfg_i.in_low;
      a_mag_q  <= mag_d;
    end
    if (b_ready && a_valid_q) begin
      b_q.side <= a_side_q;
      b_q.prod <= PROD_BITS'(a_mag_q) * PROD_BITS'(a_off_q);
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_o       = b_q;

endmodule

`default_nettype wire

// ===== sv/iwm_div.sv =====
`default_nettype none

module iwm_div import iwm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire pix_t  divisor_i,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire prod_t in_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output quot_t      out_o
);

  typedef struct packed {
    pix_t rem;
    pix_t lo;
    pix_t quo;
  } div_state_t;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  function automatic div_state_t div_step(div_state_t st, pix_t dvs);
    logic [PIXEL_BITS:0] trial;
    logic                fits;
    div_state_t          nx;
    trial  = {st.rem, st.lo[PIXEL_BITS-1]};
    fits   = trial >= {1'b0, dvs};
    nx.rem = fits ? PIXEL_BITS'(trial - {1'b0, dvs}) : PIXEL_BITS'(trial);
    nx.lo  = {st.lo[PIXEL_BITS-2:0], 1'b0};
    nx.quo = {st.quo[PIXEL_BITS-2:0], fits};
    return nx;
  endfunction

  logic       st_valid_q [DIV_STAGES];
  div_state_t st_q       [DIV_STAGES];
  side_t      st_side_q  [DIV_STAGES];
  logic [DIV_STAGES:0] rdy;

  logic       v_in [DIV_STAGES];
  div_state_t d_in [DIV_STAGES];
  side_t      s_in [DIV_STAGES];

  assign rdy[DIV_STAGES] = out_ready_i;
  assign in_ready_o      = rdy[0];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    localparam int unsigned FIRST = s * DIV_BITS;
    div_state_t d_next;

    if (s == 0) begin : g_head
      // Upper product half is already below the divisor on the ramp.
      assign v_in[s]     = in_valid_i;
      assign d_in[s].rem = in_i.prod[PROD_BITS-1:PIXEL_BITS];
      assign d_in[s].lo  = in_i.prod[PIXEL_BITS-1:0];
      assign d_in[s].quo = '0;
      assign s_in[s]     = in_i.side;
    end else begin : g_body
      assign v_in[s] = st_valid_q[s-1];
      assign d_in[s] = st_q[s-1];
      assign s_in[s] = st_side_q[s-1];
    end

    assign rdy[s] = !st_valid_q[s] || rdy[s+1];

    always_comb begin
      d_next = d_in[s];
      for (int k = 0; k < DIV_BITS; k++) begin
        if (FIRST + k < PIXEL_BITS) begin
          d_next = div_step(d_next, divisor_i);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_valid_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        st_valid_q[s] <= v_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && v_in[s]) begin
        st_q[s]      <= d_next;
        st_side_q[s] <= s_in[s];
      end
    end
  end

  assign out_valid_o  = st_valid_q[DIV_STAGES-1];
  assign out_o.side   = st_side_q[DIV_STAGES-1];
  assign out_o.quo    = st_q[DIV_STAGES-1].quo;
  assign out_o.rem_nz = |st_q[DIV_STAGES-1].rem;

endmodule

`default_nettype wire

// ===== sv/iwm_pack.sv =====
`default_nettype none

module iwm_pack import iwm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire quot_t in_i,
  iwm_res_if.source  res_o
);

  logic    valid_q;
  pix_t    pixel_q;
  region_e region_q;
  pix_t    pixel_d;
  logic    ready;

  assign ready      = !valid_q || res_o.ready;
  assign in_ready_o = ready;

  // Negative ramp rounds toward minus infinity: take the ceiling off out_low.
  always_comb begin
    case (in_i.side.region)
      REGION_BELOW: pixel_d = cfg_i.out_low;
      REGION_RAMP: begin
        if (in_i.side.neg) begin
          pixel_d = cfg_i.out_low - in_i.quo - PIXEL_BITS'(in_i.rem_nz);
        end else begin
          pixel_d = cfg_i.out_low + in_i.quo;
        end
      end
      default: pixel_d = cfg_i.out_high;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && in_valid_i) begin
      pixel_q  <= pixel_d;
      region_q <= in_i.side.region;
    end
  end

  assign res_o.valid     = valid_q;
  assign res_o.pixel_out = pixel_q;
  assign res_o.region    = region_q;

endmodule

`default_nettype wire

// ===== sv/intensity_window_map_core.sv =====
// Channel  | Dir | Payload                    | Handshake
// ---------+-----+----------------------------+-------------------------
// pix_i    | in  | pixel_in                   | valid/ready, transfer on both high
// res_o    | out | pixel_out, region          | valid/ready, transfer on both high
// cfg      | in  | cfg_idx_i, cfg_wdata_i     | cfg_we_i, one write per cycle
//
// Throughput is one pixel per cycle while res_o does not stall. The pipeline is
// classify, multiply, a radix-4 restoring divider of DIV_STAGES stages, and
// the output register.
// Reset clears every valid bit and loads the default window (full range).
// Each stage holds its item until the next one frees up, so a stall on res_o
// backs up only as far as the first empty stage; nothing is dropped.
`default_nettype none

module intensity_window_map_core import iwm_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  iwm_pix_if.sink                      pix_i,
  iwm_res_if.source                    res_o,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire pix_t                    cfg_wdata_i
);

  cfg_t  cfg_q;
  pix_t  divisor;

  logic  front_valid;
  logic  front_ready;
  prod_t front_data;

  logic  div_valid;
  logic  div_ready;
  quot_t div_data;

  // Configuration registers; the user must write them only while the pipeline is empty (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_low   <= IN_LOW_RST;
      cfg_q.in_high  <= IN_HIGH_RST;
      cfg_q.out_low  <= OUT_LOW_RST;
      cfg_q.out_high <= OUT_HIGH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_IN_LOW:   cfg_q.in_low   <= cfg_wdata_i;
        CFG_IN_HIGH:  cfg_q.in_high  <= cfg_wdata_i;
        CFG_OUT_LOW:  cfg_q.out_low  <= cfg_wdata_i;
        CFG_OUT_HIGH: cfg_q.out_high <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Window width; only meaningful for ramp pixels, where it is nonzero.
  assign divisor = cfg_q.in_high - cfg_q.in_low;

  // Stages 1-2: classify against the window, form (mag * offset).
  iwm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .pixel_i     (pix_i.pixel_in),
    .out_valid_o (front_valid),
    .out_ready_i (front_ready),
    .out_o       (front_data)
  );

  // Pipelined divide by the window width; quotient fits in one pixel.
  iwm_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .divisor_i   (divisor),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_i        (front_data),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .out_o       (div_data)
  );

  // Final select of the level and output register.
  iwm_pack u_pack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (div_valid),
    .in_ready_o (div_ready),
    .in_i       (div_data),
    .res_o      (res_o)
  );

  // An empty output register frees the whole chain back to the input.
  a_empty_out_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_o.valid |-> pix_i.ready)
    else $error("input stalled with an empty output register");

  a_front_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (front_valid && !front_ready) |=> (front_valid && $stable(front_data)))
    else $error("product stage lost or changed a stalled item");

  a_div_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_valid && !div_ready) |=> (div_valid && $stable(div_data)))
    else $error("divider tail lost or changed a stalled item");

  a_div_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_valid && div_ready) |=> res_o.valid)
    else $error("quotient transfer did not reach the output register");

endmodule

`default_nettype wire
